[sv/tbl_pkg.sv]
// package for the tokenized basic lister: payload types, phase codes and text tables
// depends on nothing; used by tokenized_basic_lister

package tbl_pkg;

   localparam int RunMax = 12;
   localparam int CntW   = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       end_of_run;
      logic       program_done;
      logic       header_error;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_LINK_LO = 3'd0,
      PH_LINK_HI = 3'd1,
      PH_LINE_LO = 3'd2,
      PH_LINE_HI = 3'd3,
      PH_BODY    = 3'd4,
      PH_HALT    = 3'd5
   } phase_type;

   // run of up to twelve characters, first character in the low byte
   typedef struct packed {
      logic [RunMax*8-1:0] chars;
      logic [CntW-1:0]     len;
   } run_type;

   function automatic run_type str_run(input string s);
      run_type r;
      r = '0;
      for (int i = 0; i < s.len(); i++) r.chars[i*8 +: 8] = s[i];
      r.len = CntW'(s.len());
      return r;
   endfunction

   // keyword text for tokens 0x80 to 0xcb
   function automatic run_type kw_run(input logic [6:0] idx);
      string s;
      unique case (idx)
         7'd0: s = "END";     7'd1: s = "FOR";     7'd2: s = "NEXT";   7'd3: s = "DATA";
         7'd4: s = "INPUT#";  7'd5: s = "INPUT";   7'd6: s = "DIM";    7'd7: s = "READ";
         7'd8: s = "LET";     7'd9: s = "GOTO";    7'd10: s = "RUN";   7'd11: s = "IF";
         7'd12: s = "RESTORE"; 7'd13: s = "GOSUB"; 7'd14: s = "RETURN"; 7'd15: s = "REM";
         7'd16: s = "STOP";   7'd17: s = "ON";     7'd18: s = "WAIT";  7'd19: s = "LOAD";
         7'd20: s = "SAVE";   7'd21: s = "VERIFY"; 7'd22: s = "DEF";   7'd23: s = "POKE";
         7'd24: s = "PRINT#"; 7'd25: s = "PRINT";  7'd26: s = "CONT";  7'd27: s = "LIST";
         7'd28: s = "CLR";    7'd29: s = "CMD";    7'd30: s = "SYS";   7'd31: s = "OPEN";
         7'd32: s = "CLOSE";  7'd33: s = "GET";    7'd34: s = "NEW";   7'd35: s = "TAB(";
         7'd36: s = "TO";     7'd37: s = "FN";     7'd38: s = "SPC(";  7'd39: s = "THEN";
         7'd40: s = "NOT";    7'd41: s = "STEP";   7'd42: s = "+";     7'd43: s = "-";
         7'd44: s = "*";      7'd45: s = "/";      7'd46: s = "^";     7'd47: s = "AND";
         7'd48: s = "OR";     7'd49: s = ">";      7'd50: s = "=";     7'd51: s = "<";
         7'd52: s = "SGN";    7'd53: s = "INT";    7'd54: s = "ABS";   7'd55: s = "USR";
         7'd56: s = "FRE";    7'd57: s = "POS";    7'd58: s = "SQR";   7'd59: s = "RND";
         7'd60: s = "LOG";    7'd61: s = "EXP";    7'd62: s = "COS";   7'd63: s = "SIN";
         7'd64: s = "TAN";    7'd65: s = "ATN";    7'd66: s = "PEEK";  7'd67: s = "LEN";
         7'd68: s = "STR$";   7'd69: s = "VAL";    7'd70: s = "ASC";   7'd71: s = "CHR$";
         7'd72: s = "LEFT$";  7'd73: s = "RIGHT$"; 7'd74: s = "MID$";  7'd75: s = "GO";
         default: s = "";
      endcase
      return str_run(s);
   endfunction

   function automatic string esc_name(input logic [7:0] b);
      string s;
      unique case (b)
         8'h05: s = "white";  8'h0E: s = "lower";  8'h11: s = "down";   8'h12: s = "rvon";
         8'h13: s = "home";   8'h14: s = "del";    8'h1C: s = "red";    8'h1D: s = "right";
         8'h1E: s = "green";  8'h1F: s = "blue";   8'h81: s = "orange"; 8'h8E: s = "upper";
         8'h90: s = "black";  8'h91: s = "up";     8'h92: s = "rvoff";  8'h93: s = "clr/home";
         8'h94: s = "inst";   8'h95: s = "brown";  8'h96: s = "lred";   8'h97: s = "gray1";
         8'h98: s = "gray2";  8'h99: s = "lgreen"; 8'h9A: s = "lblue";  8'h9B: s = "gray3";
         8'h9C: s = "purple"; 8'h9D: s = "left";   8'h9E: s = "yellow"; 8'h9F: s = "cyan";
         8'hFF: s = "pi";
         default: s = "";
      endcase
      return s;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
   endfunction

   // escape run: {name} or {$hh}
   function automatic run_type esc_run(input logic [7:0] b);
      string   n;
      run_type r;
      n = esc_name(b);
      if (n.len() != 0) begin
         r = str_run({"{", n, "}"});
      end else begin
         r = '0;
         r.chars[31:0] = {hex_char(b[3:0]), hex_char(b[7:4]), 8'h24, 8'h7B};
         r.chars[39:32] = 8'h7D;
         r.len = CntW'(5);
      end
      return r;
   endfunction

endpackage

[sv/tokenized_basic_lister.sv]
// tokenized basic lister: turns a tokenized program image into its ascii listing
// a byte is parsed in the cycle it is taken; its first character shows in the next cycle
// throughput: one byte per cycle when it yields at most one character and rsp_ready is high;
// a longer run holds the output register till the one-character-per-cycle port drains it
// reset: synchronous, active high; parser returns to the link phase with quote mode clear
// depends on tbl_pkg

module tokenized_basic_lister (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tbl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tbl_pkg::rsp_type rsp_data
);
   import tbl_pkg::*;

   phase_type           phase_ff, phase_in;
   logic                quote_ff, quote_in;
   logic [7:0]          link_lo_ff, link_lo_in;
   logic [7:0]          line_lo_ff, line_lo_in;
   logic [RunMax*8-1:0] buf_ff, buf_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                empty_ff, empty_in;
   logic                done_ff, done_in, herr_ff, herr_in;

   run_type    run;
   logic       done, herr, emit, take, pop, last_pop, qm;
   logic [7:0] b;
   logic [15:0] num;
   logic [3:0] d4, d3, d2, d1, d0;
   logic [16:0] q10, q100, q1000, q10000;
   logic [32:0] p10, p100, p1000, p10000;

   assign b    = req_data.data_byte;
   assign pop  = rsp_valid && rsp_ready;
   assign last_pop = pop && (cnt_ff == CntW'(1));
   assign req_ready = (cnt_ff == '0) || last_pop;
   assign take = req_valid && req_ready;

   // decimal digits of the line number by reciprocal multiplication
   assign num    = {b, line_lo_ff};
   assign p10    = 33'(num) * 33'd52429;
   assign p100   = 33'(num) * 33'd83887;
   assign p1000  = 33'(num) * 33'd67109;
   assign p10000 = 33'(num) * 33'd107375;
   assign q10    = 17'(p10 >> 19);
   assign q100   = 17'(p100 >> 23);
   assign q1000  = 17'(p1000 >> 26);
   assign q10000 = 17'(p10000 >> 30);
   assign d4 = 4'(q10000);
   assign d3 = 4'(q1000 - q10000 * 17'd10);
   assign d2 = 4'(q100 - q1000 * 17'd10);
   assign d1 = 4'(q10 - q100 * 17'd10);
   assign d0 = 4'(17'(num) - q10 * 17'd10);

   // parse one byte and build its run
   always_comb begin
      phase_in = req_data.first_byte ? PH_LINK_LO : phase_ff;
      qm       = req_data.first_byte ? 1'b0 : quote_ff;
      quote_in = qm;
      link_lo_in = link_lo_ff;
      line_lo_in = line_lo_ff;
      run  = '0;
      done = 1'b0;
      herr = 1'b0;
      unique case (phase_in)
         PH_LINK_LO: begin
            link_lo_in = b;
            if (req_data.last_byte) done = 1'b1;
            else phase_in = PH_LINK_HI;
         end
         PH_LINK_HI: begin
            if (link_lo_ff == 8'd0 && b == 8'd0) done = 1'b1;
            else if (req_data.last_byte) herr = 1'b1;
            else phase_in = PH_LINE_LO;
         end
         PH_LINE_LO: begin
            line_lo_in = b;
            if (req_data.last_byte) herr = 1'b1;
            else phase_in = PH_LINE_HI;
         end
         PH_LINE_HI: begin
            priority if (num >= 16'd10000) begin
               run.chars[39:0] = {4'h3,d0,4'h3,d1,4'h3,d2,4'h3,d3,4'h3,d4};
               run.len = CntW'(5);
            end else if (num >= 16'd1000) begin
               run.chars[31:0] = {4'h3,d0,4'h3,d1,4'h3,d2,4'h3,d3};
               run.len = CntW'(4);
            end else if (num >= 16'd100) begin
               run.chars[23:0] = {4'h3,d0,4'h3,d1,4'h3,d2};
               run.len = CntW'(3);
            end else if (num >= 16'd10) begin
               run.chars[15:0] = {4'h3,d0,4'h3,d1};
               run.len = CntW'(2);
            end else begin
               run.chars[7:0] = {4'h3,d0};
               run.len = CntW'(1);
            end
            run.chars[run.len*8 +: 8] = 8'h20;
            run.len = run.len + CntW'(1);
            quote_in = 1'b0;
            if (req_data.last_byte) begin
               run.chars[run.len*8 +: 8] = 8'h0A;
               run.len = run.len + CntW'(1);
               done = 1'b1;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (b == 8'd0) begin
               run.chars[7:0] = 8'h0A;
               run.len = CntW'(1);
               if (req_data.last_byte) done = 1'b1;
               else phase_in = PH_LINK_LO;
            end else begin
               priority if (b == 8'h22) begin
                  quote_in = ~qm;
                  run = str_run("\"");
               end else if (!qm && b >= 8'h80) begin
                  if (b <= 8'hCB) run = kw_run(7'(b - 8'h80));
                  else run = esc_run(b);
               end else if (b >= 8'h20 && b <= 8'h7E && b != 8'h7B && b != 8'h7D) begin
                  run.chars[7:0] = b;
                  run.len = CntW'(1);
               end else if (b >= 8'hC1 && b <= 8'hDA) begin
                  run.chars[7:0] = b - 8'hC1 + 8'h41;
                  run.len = CntW'(1);
               end else begin
                  run = esc_run(b);
               end
               if (req_data.last_byte) begin
                  run.chars[run.len*8 +: 8] = 8'h0A;
                  run.len = run.len + CntW'(1);
                  done = 1'b1;
               end
            end
         end
         default: begin
            run = '0;
         end
      endcase
      if (done || herr) phase_in = PH_HALT;
   end

   assign emit = (run.len != '0) || done || herr;

   // output run register
   always_comb begin
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      empty_in = empty_ff;
      done_in  = done_ff;
      herr_in  = herr_ff;
      if (pop) begin
         buf_in = buf_ff >> 8;
         cnt_in = cnt_ff - CntW'(1);
      end
      if (take && emit) begin
         buf_in   = run.chars;
         cnt_in   = (run.len == '0) ? CntW'(1) : run.len;
         empty_in = (run.len == '0);
         done_in  = done;
         herr_in  = herr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LINK_LO;
         quote_ff   <= 1'b0;
         link_lo_ff <= 8'd0;
         line_lo_ff <= 8'd0;
         cnt_ff     <= '0;
      end else begin
         if (take) begin
            phase_ff   <= phase_in;
            quote_ff   <= quote_in;
            link_lo_ff <= link_lo_in;
            line_lo_ff <= line_lo_in;
         end
         cnt_ff <= cnt_in;
      end
      buf_ff   <= buf_in;
      empty_ff <= empty_in;
      done_ff  <= done_in;
      herr_ff  <= herr_in;
   end

   // result port
   assign rsp_valid = (cnt_ff != '0);
   always_comb begin
      rsp_data.out_char     = empty_ff ? 8'd0 : buf_ff[7:0];
      rsp_data.char_valid   = ~empty_ff;
      rsp_data.end_of_run   = (cnt_ff == CntW'(1));
      rsp_data.program_done = (cnt_ff == CntW'(1)) && done_ff;
      rsp_data.header_error = (cnt_ff == CntW'(1)) && herr_ff;
   end

endmodule
